// ----- rtl/bth_pkg.sv -----
package bth_pkg;

  localparam int OFF_W = 16;
  localparam int REQ_W = 16;
  localparam int ST_W  = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO    = 2'd2;
  localparam logic [ST_W-1:0] ST_BADFREE = 2'd3;

  localparam int TAG_BYTES   = 4;
  localparam int ALIGN_BYTES = 8;
  localparam int MIN_BLOCK   = 2 * ALIGN_BYTES;
  localparam int FIRST_BLOCK = 12;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_ALLOC,
    OP_FREE
  } op_t;

endpackage

// ----- rtl/bth_if.sv -----
interface bth_req_if;
  import bth_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] payload_offset;
  modport source (output valid, kind, request_bytes, payload_offset, input ready);
  modport sink   (input valid, kind, request_bytes, payload_offset, output ready);
endinterface

interface bth_rsp_if;
  import bth_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] result_offset;
  logic [ST_W-1:0]  status;
  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface

// ----- rtl/bth_tag_ram.sv -----
module bth_tag_ram #(
  parameter int WORDS = 16384,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  localparam int IW = $clog2(WORDS);
  localparam logic [AW-1:0] BYTES = AW'(WORDS * 4);

  logic [31:0] mem [WORDS];
  logic [31:0] q;
  logic        oob;

  always_ff @(posedge clk) begin
    if (we && waddr < BYTES) begin
      mem[waddr[IW+1:2]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    q   <= mem[raddr[IW+1:2]];
    oob <= raddr >= BYTES;
  end

  // beyond the heap reads as zero
  assign rdata = oob ? 32'd0 : q;
endmodule

// ----- rtl/boundary_tag_heap_allocator.sv -----
// First-fit heap allocator with boundary tags held in a single-port-read tag RAM. One request
// is handled at a time; the walk visits one block tag per cycle on the RAM read port. An
// allocate walks the blocks up to the fit and writes its tags, plus the remainder's when
// split; each heap growth writes a new chunk, merges it and walks again from the first block.
// A free walks the blocks up to the one freed and merges it with free neighbours; null and
// zero-size requests, and frees below the tag size, answer without a walk. After reset the
// tag RAM is built before the first request is taken; the RAM itself is never swept.
module boundary_tag_heap_allocator #(
  parameter int HEAP_WORDS  = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input logic      clk,
  input logic      rst,
  bth_req_if.sink  req,
  bth_rsp_if.source rsp
);
  import bth_pkg::*;

  localparam int AW = ($clog2(HEAP_WORDS) + 3 > 18) ? $clog2(HEAP_WORDS) + 3 : 18;
  localparam logic [AW-1:0] HEAP_BYTES = AW'(HEAP_WORDS * 4);
  localparam logic [AW-1:0] CHUNK      = AW'(CHUNK_BYTES);
  localparam logic [AW-1:0] TAGB       = AW'(TAG_BYTES);
  localparam logic [AW-1:0] ALIGNB     = AW'(ALIGN_BYTES);
  localparam logic [AW-1:0] MINB       = AW'(MIN_BLOCK);
  localparam logic [AW-1:0] FIRSTB     = AW'(FIRST_BLOCK);

  typedef enum logic [4:0] {
    S_INIT1, S_INIT2, S_INIT3,
    S_GCHK, S_GW1, S_GW2, S_GW3,
    S_CA, S_CB, S_CC, S_CD, S_CW1, S_CW2,
    S_IDLE, S_FA, S_FB,
    S_P0, S_P1, S_P2, S_P3,
    S_LA, S_LB, S_OUT
  } state_t;

  state_t          state;
  op_t             op;
  logic [AW-1:0]   hdr, target, need, have, endp, start, heap_end;
  logic            split;
  logic [OFF_W-1:0] p_off, o_off;
  logic [ST_W-1:0]  p_st, o_st;
  logic             ov;

  logic [AW-1:0] raddr, waddr, wsize, psz, rsize;
  logic          we, wused, rused;
  logic [31:0]   rdata, wdata;

  bth_tag_ram #(.WORDS(HEAP_WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .raddr (raddr),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign rsize = {rdata[AW-1:3], 3'b000};
  assign rused = rdata[0];
  assign psz   = split ? need : have;
  assign wdata = {{(32 - AW){1'b0}}, wsize[AW-1:3], 2'b00, wused};

  always_comb begin
    raddr = hdr;
    we    = 1'b0;
    waddr = hdr;
    wsize = '0;
    wused = 1'b0;
    case (state)
      S_INIT1: begin we = 1'b1; waddr = TAGB;     wsize = ALIGNB; wused = 1'b1; end
      S_INIT2: begin we = 1'b1; waddr = ALIGNB;   wsize = ALIGNB; wused = 1'b1; end
      S_INIT3: begin we = 1'b1; waddr = FIRSTB;   wused = 1'b1; end
      S_GW1:   begin we = 1'b1; waddr = hdr;      wsize = CHUNK; end
      S_GW2:   begin we = 1'b1; waddr = hdr + CHUNK - TAGB; wsize = CHUNK; end
      S_GW3:   begin we = 1'b1; waddr = hdr + CHUNK; wused = 1'b1; end
      S_CB, S_FB, S_LB: raddr = hdr + rsize;
      S_CC:    raddr = hdr - TAGB;
      S_CW1:   begin we = 1'b1; waddr = start; wsize = endp - start; end
      S_CW2:   begin we = 1'b1; waddr = endp - TAGB; wsize = endp - start; end
      S_P0:    begin we = 1'b1; waddr = hdr; wsize = psz; wused = 1'b1; end
      S_P1:    begin we = 1'b1; waddr = hdr + psz - TAGB; wsize = psz; wused = 1'b1; end
      S_P2:    begin we = 1'b1; waddr = hdr + need; wsize = have - need; end
      S_P3:    begin we = 1'b1; waddr = hdr + have - TAGB; wsize = have - need; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT1;
      op    <= OP_INIT;
      ov    <= 1'b0;
    end else begin
      if (rsp.ready && state != S_OUT) ov <= 1'b0;
      case (state)
        S_INIT1: state <= S_INIT2;
        S_INIT2: state <= S_INIT3;
        S_INIT3: begin
          heap_end <= AW'(16);
          state    <= S_GCHK;
        end
        S_GCHK: begin
          if (heap_end + CHUNK > HEAP_BYTES) begin
            if (op == OP_INIT) begin
              state <= S_IDLE;
            end else begin
              p_off <= '0;
              p_st  <= ST_NOMEM;
              state <= S_OUT;
            end
          end else begin
            hdr   <= heap_end - TAGB;
            state <= S_GW1;
          end
        end
        S_GW1: state <= S_GW2;
        S_GW2: state <= S_GW3;
        S_GW3: begin
          heap_end <= heap_end + CHUNK;
          state    <= S_CA;
        end
        S_CA: state <= S_CB;
        S_CB: begin
          endp  <= hdr + rsize;
          state <= S_CC;
        end
        S_CC: begin
          if (!rused) endp <= endp + rsize;
          state <= S_CD;
        end
        S_CD: begin
          start <= rused ? hdr : hdr - rsize;
          state <= S_CW1;
        end
        S_CW1: state <= S_CW2;
        S_CW2: begin
          case (op)
            OP_FREE: begin
              p_off <= '0;
              p_st  <= ST_OK;
              state <= S_OUT;
            end
            OP_ALLOC: begin
              hdr   <= FIRSTB;
              state <= S_FA;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_IDLE: begin
          if (req.valid) begin
            hdr <= FIRSTB;
            if (req.kind == KIND_ALLOC) begin
              op <= OP_ALLOC;
              if (req.request_bytes == '0) begin
                p_off <= '0;
                p_st  <= ST_ZERO;
                state <= S_OUT;
              end else begin
                if (AW'(req.request_bytes) <= ALIGNB) begin
                  need <= MINB;
                end else begin
                  need <= (AW'(req.request_bytes) + MINB - AW'(1)) & ~AW'(7);
                end
                state <= S_FA;
              end
            end else begin
              op <= OP_FREE;
              if (req.payload_offset == '0) begin
                p_off <= '0;
                p_st  <= ST_OK;
                state <= S_OUT;
              end else if (AW'(req.payload_offset) < TAGB) begin
                p_off <= '0;
                p_st  <= ST_BADFREE;
                state <= S_OUT;
              end else begin
                target <= AW'(req.payload_offset) - TAGB;
                state  <= S_LA;
              end
            end
          end
        end
        S_FA: state <= S_FB;
        S_FB: begin
          if (rsize == '0) begin
            state <= S_GCHK;
          end else if (!rused && need <= rsize) begin
            have  <= rsize;
            split <= (rsize - need) >= MINB;
            state <= S_P0;
          end else begin
            hdr <= hdr + rsize;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          if (split) begin
            state <= S_P2;
          end else begin
            p_off <= OFF_W'(hdr + TAGB);
            p_st  <= ST_OK;
            state <= S_OUT;
          end
        end
        S_P2: state <= S_P3;
        S_P3: begin
          p_off <= OFF_W'(hdr + TAGB);
          p_st  <= ST_OK;
          state <= S_OUT;
        end
        S_LA: state <= S_LB;
        S_LB: begin
          if (rsize == '0 || hdr > target || (hdr == target && !rused)) begin
            p_off <= '0;
            p_st  <= ST_BADFREE;
            state <= S_OUT;
          end else if (hdr == target) begin
            state <= S_CA;
          end else begin
            hdr <= hdr + rsize;
          end
        end
        S_OUT: begin
          if (!ov || rsp.ready) begin
            ov    <= 1'b1;
            o_off <= p_off;
            o_st  <= p_st;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = ov;
  assign rsp.result_offset = o_off;
  assign rsp.status        = o_st;

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    heap_end <= HEAP_BYTES || state == S_INIT1 || state == S_INIT2 || state == S_INIT3)
    else $error("heap end beyond heap");

  a_align: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && p_st == ST_OK && p_off != '0) |-> p_off[2:0] == 3'b000)
    else $error("misaligned payload");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_OUT) |-> !we)
    else $error("tag write outside a request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> rsp.result_offset == '0)
    else $error("offset on failed beat");
endmodule

// ----- sim/boundary_tag_heap_allocator_test.sv -----
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_test;
  import bth_pkg::*;

  localparam int HEAP_WORDS  = 16384;
  localparam int CHUNK_BYTES = 4096;
  localparam int HEAP_BYTES  = HEAP_WORDS * TAG_BYTES;
  localparam int RANDOM_BEATS = 850;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [ST_W-1:0]  status;
  } answer_t;

  typedef struct {
    logic             kind;
    logic [REQ_W-1:0] bytes;
    logic [OFF_W-1:0] payload;
    bit               known;
    answer_t          answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bth_req_if req ();
  bth_rsp_if rsp ();

  boundary_tag_heap_allocator #(
    .HEAP_WORDS (HEAP_WORDS),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // allocator shadow
  logic [31:0] heap_tags [HEAP_WORDS];
  int unsigned heap_top;
  answer_t     awaited [$];
  logic [OFF_W-1:0] live_payloads [$];
  int errors, accepted, answered;
  int n_ok_alloc, n_nomem, n_zero, n_free, n_badfree;
  bit quiet;

  function automatic int unsigned tag_rd(int unsigned addr);
    if (addr / TAG_BYTES >= HEAP_WORDS) return 0;
    return heap_tags[addr / TAG_BYTES];
  endfunction

  function automatic void tag_wr(int unsigned addr, int unsigned size, bit used);
    if (addr / TAG_BYTES < HEAP_WORDS)
      heap_tags[addr / TAG_BYTES] = (size & ~32'd7) | {31'd0, used};
  endfunction

  function automatic int unsigned size_at(int unsigned addr);
    return tag_rd(addr) & ~32'd7;
  endfunction

  function automatic bit used_at(int unsigned addr);
    return bit'(tag_rd(addr) & 32'd1);
  endfunction

  function automatic void merge_free(int unsigned hdr);
    int unsigned lo, hi;
    lo = hdr;
    hi = hdr + size_at(hdr);
    if (!used_at(hi)) hi = hi + size_at(hi);
    if (!used_at(hdr - TAG_BYTES)) lo = hdr - size_at(hdr - TAG_BYTES);
    tag_wr(lo, hi - lo, 1'b0);
    tag_wr(hi - TAG_BYTES, hi - lo, 1'b0);
  endfunction

  function automatic bit grow_heap();
    int unsigned hdr;
    if (heap_top > HEAP_BYTES || CHUNK_BYTES > HEAP_BYTES - heap_top) return 1'b0;
    hdr = heap_top - TAG_BYTES;
    tag_wr(hdr, CHUNK_BYTES, 1'b0);
    tag_wr(hdr + CHUNK_BYTES - TAG_BYTES, CHUNK_BYTES, 1'b0);
    tag_wr(hdr + CHUNK_BYTES, 0, 1'b1);
    heap_top += CHUNK_BYTES;
    merge_free(hdr);
    return 1'b1;
  endfunction

  function automatic bit fit_search(int unsigned need, output int unsigned where);
    int unsigned hdr, sz;
    hdr = FIRST_BLOCK;
    where = 0;
    sz = size_at(hdr);
    while (sz != 0) begin
      if (!used_at(hdr) && need <= sz) begin
        where = hdr;
        return 1'b1;
      end
      hdr += sz;
      sz = size_at(hdr);
    end
    return 1'b0;
  endfunction

  function automatic void carve(int unsigned hdr, int unsigned need);
    int unsigned have;
    have = size_at(hdr);
    if (have - need < MIN_BLOCK) begin
      tag_wr(hdr, have, 1'b1);
      tag_wr(hdr + have - TAG_BYTES, have, 1'b1);
    end else begin
      tag_wr(hdr, need, 1'b1);
      tag_wr(hdr + need - TAG_BYTES, need, 1'b1);
      tag_wr(hdr + need, have - need, 1'b0);
      tag_wr(hdr + have - TAG_BYTES, have - need, 1'b0);
    end
  endfunction

  function automatic bit owns_live(int unsigned hdr);
    int unsigned p, sz;
    p = FIRST_BLOCK;
    sz = size_at(p);
    while (sz != 0 && p <= hdr) begin
      if (p == hdr) return used_at(p);
      p += sz;
      sz = size_at(p);
    end
    return 1'b0;
  endfunction

  function automatic void heap_reset();
    foreach (heap_tags[i]) heap_tags[i] = '0;
    tag_wr(4, ALIGN_BYTES, 1'b1);
    tag_wr(8, ALIGN_BYTES, 1'b1);
    tag_wr(12, 0, 1'b1);
    heap_top = 16;
    void'(grow_heap());
  endfunction

  function automatic answer_t heap_step(logic kind, logic [REQ_W-1:0] bytes,
                                        logic [OFF_W-1:0] payload);
    answer_t a;
    int unsigned need, hdr;
    bit found;
    a = '{offset: '0, status: ST_OK};
    if (kind == KIND_ALLOC) begin
      if (bytes == 0) begin
        a.status = ST_ZERO;
      end else begin
        need = (bytes <= ALIGN_BYTES) ? MIN_BLOCK
             : (int'(bytes) + 2 * ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
        found = fit_search(need, hdr);
        while (!found) begin
          if (!grow_heap()) break;
          found = fit_search(need, hdr);
        end
        if (found) begin
          carve(hdr, need);
          a.offset = OFF_W'(hdr + TAG_BYTES);
        end else begin
          a.status = ST_NOMEM;
        end
      end
    end else if (payload != 0) begin
      if (payload >= TAG_BYTES && owns_live(payload - TAG_BYTES))
        merge_free(payload - TAG_BYTES);
      else
        a.status = ST_BADFREE;
    end
    return a;
  endfunction

  task automatic report(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic book(answer_t a, logic kind);
    case (a.status)
      ST_OK:      if (kind == KIND_ALLOC) n_ok_alloc++; else n_free++;
      ST_NOMEM:   n_nomem++;
      ST_ZERO:    n_zero++;
      ST_BADFREE: n_badfree++;
      default: ;
    endcase
  endtask

  // send one beat; prediction is made at acceptance
  task automatic offer(logic kind, logic [REQ_W-1:0] bytes, logic [OFF_W-1:0] payload,
                       bit known, answer_t given);
    answer_t a;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.kind = kind;
    req.request_bytes = bytes;
    req.payload_offset = payload;
    do @(posedge clk); while (!req.ready);
    a = heap_step(kind, bytes, payload);
    if (known && a != given)
      report($sformatf("shadow disagrees with table row: %0d/%0d vs %0d/%0d",
                       a.offset, a.status, given.offset, given.status));
    awaited.push_back(known ? given : a);
    book(a, kind);
    if (kind == KIND_ALLOC && a.status == ST_OK) live_payloads.push_back(a.offset);
    accepted++;
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      answered++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat offset=%0d status=%0d",
                         rsp.result_offset, rsp.status));
      end else begin
        want = awaited.pop_front();
        if (rsp.result_offset !== want.offset)
          report($sformatf("result_offset %0d, expected %0d", rsp.result_offset, want.offset));
        if (rsp.status !== want.status)
          report($sformatf("status %0d, expected %0d", rsp.status, want.status));
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    bit held;
    int n;
    held = 1'b0;
    rsp.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if (!held && accepted >= 300) begin
        held = 1'b1;
        rsp.ready = 1'b0;
        for (n = 0; n < 400; n++) @(negedge clk);
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp.ready = 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
      end
      rsp.ready = 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    #400_000_000;
    $display("boundary_tag_heap_allocator regression: fail");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t r;
    int i, pick, lim, roll;
    logic [REQ_W-1:0] b;
    logic [OFF_W-1:0] p;

    req.valid = 1'b0;
    req.kind = KIND_ALLOC;
    req.request_bytes = '0;
    req.payload_offset = '0;
    heap_reset();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    rows = '{
      '{KIND_ALLOC, 16'd1,     16'd0,     1'b1, '{16'd16, ST_OK}},
      '{KIND_ALLOC, 16'd0,     16'hFFFF,  1'b1, '{16'd0,  ST_ZERO}},
      '{KIND_FREE,  16'hFFFF,  16'd0,     1'b1, '{16'd0,  ST_OK}},
      '{KIND_FREE,  16'd0,     16'd16,    1'b1, '{16'd0,  ST_OK}},
      '{KIND_FREE,  16'd0,     16'd16,    1'b1, '{16'd0,  ST_BADFREE}},
      '{KIND_FREE,  16'd0,     16'd2,     1'b1, '{16'd0,  ST_BADFREE}},
      '{KIND_FREE,  16'd0,     16'hFFFF,  1'b1, '{16'd0,  ST_BADFREE}},
      '{KIND_ALLOC, 16'hFFFF,  16'd0,     1'b1, '{16'd0,  ST_NOMEM}},
      '{KIND_ALLOC, 16'd8,     16'd0,     1'b1, '{16'd16, ST_OK}},
      '{KIND_ALLOC, 16'd9,     16'd0,     1'b1, '{16'd32, ST_OK}},
      '{KIND_ALLOC, 16'd100,   16'd0,     1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd36,    1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd32,    1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd16,    1'b0, '0},
      '{KIND_ALLOC, 16'd61424, 16'd0,     1'b0, '0},
      '{KIND_ALLOC, 16'd1,     16'd0,     1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd16,    1'b0, '0},
      '{KIND_ALLOC, 16'd24,    16'd0,     1'b0, '0},
      '{KIND_ALLOC, 16'd24,    16'd0,     1'b0, '0},
      '{KIND_ALLOC, 16'd24,    16'd0,     1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd48,    1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd16,    1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd80,    1'b0, '0},
      '{KIND_FREE,  16'd0,     16'd80,    1'b0, '0}
    };
    foreach (rows[k]) begin
      r = rows[k];
      offer(r.kind, r.bytes, r.payload, r.known, r.answer);
      // the shadow tracks live blocks; drop whatever the table freed
      if (r.kind == KIND_FREE)
        foreach (live_payloads[j])
          if (live_payloads[j] == r.payload) begin
            live_payloads.delete(j);
            break;
          end
    end

    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (i > RANDOM_BEATS - 120) quiet = 1'b1;
      roll = $urandom_range(0, 99);
      lim = (live_payloads.size() > 120) ? 30 : 55;
      if (roll < lim) begin
        case ($urandom_range(0, 19))
          0:       b = 16'd0;
          1:       b = REQ_W'($urandom);
          2, 3:    b = REQ_W'($urandom_range(1024, 8192));
          default: b = REQ_W'($urandom_range(1, 200));
        endcase
        offer(KIND_ALLOC, b, OFF_W'($urandom), 1'b0, '0);
      end else if (roll < 88 && live_payloads.size() > 0) begin
        pick = $urandom_range(0, live_payloads.size() - 1);
        p = live_payloads[pick];
        live_payloads.delete(pick);
        offer(KIND_FREE, REQ_W'($urandom), p, 1'b0, '0);
      end else begin
        case ($urandom_range(0, 3))
          0: p = 16'd0;
          1: p = OFF_W'($urandom);
          2: p = OFF_W'($urandom_range(0, 64));
          default: p = live_payloads.size() ? OFF_W'(live_payloads[0] + 8)
                                            : OFF_W'($urandom);
        endcase
        offer(KIND_FREE, REQ_W'($urandom), p, 1'b0, '0);
        // a random offset may land on a live payload and free it
        if (awaited.size() && awaited[$].status == ST_OK && p != 0)
          foreach (live_payloads[j])
            if (live_payloads[j] == p) begin
              live_payloads.delete(j);
              break;
            end
      end
    end

    lim = 0;
    while (awaited.size() != 0 && lim < 200000) begin
      @(posedge clk);
      lim++;
    end
    if (awaited.size() != 0) report($sformatf("%0d answers never came", awaited.size()));
    repeat (50) @(posedge clk);

    $display("%0d requests, %0d answers: %0d allocations placed, %0d out of memory,",
             accepted, answered, n_ok_alloc, n_nomem);
    $display("%0d zero-size, %0d good or null frees, %0d invalid frees",
             n_zero, n_free, n_badfree);
    if (errors == 0) begin
      $display("boundary_tag_heap_allocator regression: pass");
    end else begin
      $display("boundary_tag_heap_allocator regression: fail");
    end
    $finish;
  end

endmodule
